[src/rpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB point filter package
// Pixel request types, filter mode codes and register indexes shared by the
// point filter unit and its port list.
// ----------------------------------------------------------------------------
package rpf_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned OFFS_W = 9;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
    localparam logic [CHAN_W-1:0] THRESH_RESET = 8'd127;

    // mean = (sum * 683) >> 11 is exact for every sum below 2048
    localparam logic [9:0] DIV3_MUL = 10'd683;
    localparam int unsigned DIV3_SHIFT = 11;

    typedef enum logic [1:0] {
        MODE_THRESHOLD = 2'd0,
        MODE_GRAYSCALE = 2'd1,
        MODE_NEGATIVE  = 2'd2,
        MODE_OFFSET    = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_MODE     = 3'd0,
        CFG_THRESHOLD_LEVEL = 3'd1,
        CFG_OFFSET_RED      = 3'd2,
        CFG_OFFSET_GREEN    = 3'd3,
        CFG_OFFSET_BLUE     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } t_pixel_in;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
    } t_pixel_out;

    // Add a signed offset to one channel and clamp to 0..255
    function automatic logic [CHAN_W-1:0] add_sat(
        input logic [CHAN_W-1:0] chan,
        input logic signed [OFFS_W-1:0] offs
    );
        logic signed [OFFS_W:0] sum;
        begin
            sum = $signed({2'b00, chan}) + $signed({offs[OFFS_W-1], offs});
            if (sum[OFFS_W]) begin
                add_sat = '0;
            end else if (sum[OFFS_W-1]) begin
                add_sat = CHAN_MAX;
            end else begin
                add_sat = sum[CHAN_W-1:0];
            end
        end
    endfunction

endpackage

[src/rgb_point_filter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB point filter unit
// Per-pixel point filter: threshold to black/white, grayscale, negative or
// saturating per-channel offset, selected by the filter mode register.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+--------------------------
//  in        | input     | i_in_valid/o_in_ready| i_in_pixel  (t_pixel_in)
//  out       | output    | o_out_valid/i_out_ready | o_out_pixel (t_pixel_out)
//  cfg       | input     | i_cfg_we (no wait)   | i_cfg_idx, i_cfg_wdata
//
//  One pixel per clock sustained while i_out_ready is high; each pixel
//  passes the input register, then the filter logic into the result register.
//  Throughput is set by the two-stage register pipeline; each stage advances
//  whenever the stage after it is empty or moving.
//  A stall on the output fills both stages, then o_in_ready drops.
//  Synchronous active-low reset empties both stages and loads register
//  defaults (mode threshold, level 127, offsets zero).
// ----------------------------------------------------------------------------
module rgb_point_filter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rpf_pkg::t_pixel_in                  i_in_pixel,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rpf_pkg::t_pixel_out                 o_out_pixel,
    input  logic                                i_cfg_we,
    input  logic [rpf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rpf_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import rpf_pkg::*;

    t_mode                    r_mode;
    logic [CHAN_W-1:0]        r_thresh;
    logic signed [OFFS_W-1:0] r_offs_red;
    logic signed [OFFS_W-1:0] r_offs_green;
    logic signed [OFFS_W-1:0] r_offs_blue;

    logic       r_s1_valid;
    t_pixel_in  r_s1_pix;
    logic       r_s2_valid;
    t_pixel_out r_s2_pix;

    logic       s2_load;
    logic [9:0] sum;
    logic [19:0] prod;
    logic [CHAN_W-1:0] mean;
    t_pixel_out n_s2_pix;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_THRESHOLD;
            r_thresh     <= THRESH_RESET;
            r_offs_red   <= '0;
            r_offs_green <= '0;
            r_offs_blue  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILTER_MODE:     r_mode       <= t_mode'(i_cfg_wdata[1:0]);
                CFG_THRESHOLD_LEVEL: r_thresh     <= i_cfg_wdata[CHAN_W-1:0];
                CFG_OFFSET_RED:      r_offs_red   <= i_cfg_wdata;
                CFG_OFFSET_GREEN:    r_offs_green <= i_cfg_wdata;
                CFG_OFFSET_BLUE:     r_offs_blue  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    assign s2_load    = r_s1_valid && (!r_s2_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s2_load;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_pix <= i_in_pixel;
        end
    end

    // Mean of three channels by reciprocal multiply
    assign sum  = {2'b00, r_s1_pix.red_in} + {2'b00, r_s1_pix.green_in}
                + {2'b00, r_s1_pix.blue_in};
    assign prod = {10'd0, sum} * {10'd0, DIV3_MUL};
    assign mean = prod[DIV3_SHIFT +: CHAN_W];

    // Filter select
    always_comb begin
        unique case (r_mode)
            MODE_THRESHOLD: begin
                n_s2_pix.red_out = (mean < r_thresh) ? '0 : CHAN_MAX;
                n_s2_pix.green_out = n_s2_pix.red_out;
                n_s2_pix.blue_out  = n_s2_pix.red_out;
            end
            MODE_GRAYSCALE: begin
                n_s2_pix.red_out   = mean;
                n_s2_pix.green_out = mean;
                n_s2_pix.blue_out  = mean;
            end
            MODE_NEGATIVE: begin
                n_s2_pix.red_out   = CHAN_MAX - r_s1_pix.red_in;
                n_s2_pix.green_out = CHAN_MAX - r_s1_pix.green_in;
                n_s2_pix.blue_out  = CHAN_MAX - r_s1_pix.blue_in;
            end
            MODE_OFFSET: begin
                n_s2_pix.red_out   = add_sat(r_s1_pix.red_in, r_offs_red);
                n_s2_pix.green_out = add_sat(r_s1_pix.green_in, r_offs_green);
                n_s2_pix.blue_out  = add_sat(r_s1_pix.blue_in, r_offs_blue);
            end
            default: begin
                n_s2_pix = '0;
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_load) begin
            r_s2_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2_pix <= n_s2_pix;
        end
    end

    assign o_out_valid = r_s2_valid;
    assign o_out_pixel = r_s2_pix;

`ifndef SYNTHESIS
    // A new result only appears after the input stage held a request
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a staged request");

    // Ready low only while the input stage is full and blocked
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_s2_valid && !i_out_ready))
        else $error("input stalled without a full pipeline");

    // Negative mode inverts every channel; this check covers red and blue
    a_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_load && r_mode == MODE_NEGATIVE) |=>
            (o_out_pixel.red_out == ~$past(r_s1_pix.red_in))
            && (o_out_pixel.blue_out == ~$past(r_s1_pix.blue_in)))
        else $error("negative result mismatch");

    // Threshold mode gives pure black or pure white
    a_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_load && r_mode == MODE_THRESHOLD) |=>
            (o_out_pixel.red_out == o_out_pixel.green_out)
            && (o_out_pixel.red_out == o_out_pixel.blue_out)
            && (o_out_pixel.red_out == '0 || o_out_pixel.red_out == CHAN_MAX))
        else $error("threshold result not black or white");
`endif

endmodule
